// ===== src/mri_pkg.sv =====
// ----------------------------------------------------------------------------
// mri_pkg: shared types and constants for the MLP ReLU inference core
// Fixed field widths, command codes, datapath control struct and ReLU helper.
// ----------------------------------------------------------------------------
package mri_pkg;

  localparam int IDX_W      = 7;   // weight index field
  localparam int WT_W       = 16;  // Q4.12 weight
  localparam int ACT_W      = 16;  // Q8.8 activation
  localparam int OUT_W      = 15;  // saturated ReLU result
  localparam int PROD_W     = WT_W + ACT_W;
  localparam int ACC_W      = 40;
  localparam int FRAC_SHIFT = 12;

  localparam logic [OUT_W-1:0] ACT_MAX = '1;

  // input request command codes
  localparam logic CMD_WEIGHT  = 1'b0;
  localparam logic CMD_FEATURE = 1'b1;

  // where a finished node value goes
  typedef enum logic [1:0] {
    DST_MEM,
    DST_OUT0,
    DST_OUT1
  } mri_dst_t;

  // controller to datapath commands
  typedef struct packed {
    logic     wt_we;     // write weight from the input request
    logic     feat_we;   // write feature from the input request
    logic     rd_en;     // issue one weight/activation read
    logic     first;     // first term of a node
    logic     last;      // last term of a node
    mri_dst_t dst;       // destination of the node value
    logic     load_out;  // move node results to the output register
  } mri_cmd_t;

  // ReLU, drop 12 fraction bits (truncate), saturate to 15 bits
  function automatic logic [OUT_W-1:0] relu_sat(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] q;
    begin
      q = acc >> FRAC_SHIFT;
      if (acc <= 0) begin
        return '0;
      end
      if (q > ACC_W'(ACT_MAX)) begin
        return ACT_MAX;
      end
      return q[OUT_W-1:0];
    end
  endfunction

endpackage

// ===== src/mri_if.sv =====
// ----------------------------------------------------------------------------
// mri_if: request and result channels of the MLP ReLU inference core
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mri_in_if;
  import mri_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [IDX_W-1:0]        weight_index;
  logic signed [WT_W-1:0]  weight_value;
  logic signed [ACT_W-1:0] feature_value;

  modport source (output valid, command, weight_index, weight_value, feature_value,
                  input ready);
  modport sink (input valid, command, weight_index, weight_value, feature_value,
                output ready);
endinterface

interface mri_out_if;
  import mri_pkg::*;

  logic             valid;
  logic             ready;
  logic             decision;
  logic [OUT_W-1:0] output_zero;
  logic [OUT_W-1:0] output_one;

  modport source (output valid, decision, output_zero, output_one, input ready);
  modport sink (input valid, decision, output_zero, output_one, output ready);
endinterface

// ===== src/mri_datapath.sv =====
// ----------------------------------------------------------------------------
// mri_datapath: weight/activation memories and the shared MAC pipeline
// Read -> multiply -> accumulate -> ReLU write-back, tags follow each term.
// ----------------------------------------------------------------------------
module mri_datapath #(
  parameter int WCOUNT = 112,
  parameter int ADEPTH = 20,
  parameter int WAW    = 7,
  parameter int AAW    = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mri_pkg::mri_cmd_t               cmd,
  input  logic [WAW-1:0]                  w_raddr,
  input  logic [AAW-1:0]                  act_raddr,
  input  logic [AAW-1:0]                  dst_addr,
  input  logic [AAW-1:0]                  feat_addr,
  input  logic [mri_pkg::IDX_W-1:0]       in_weight_index,
  input  logic signed [mri_pkg::WT_W-1:0] in_weight_value,
  input  logic signed [mri_pkg::ACT_W-1:0] in_feature_value,
  output logic                            pipe_busy,
  output logic                            out_decision,
  output logic [mri_pkg::OUT_W-1:0]       out_zero,
  output logic [mri_pkg::OUT_W-1:0]       out_one
);
  import mri_pkg::*;

  logic signed [WT_W-1:0]  wmem [WCOUNT];
  logic signed [ACT_W-1:0] amem [ADEPTH];

  logic signed [WT_W-1:0]   w_rd_r;
  logic signed [ACT_W-1:0]  a_rd_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic           v1_r, v2_r, done_r;
  logic           first1_r, last1_r, first2_r, last2_r;
  mri_dst_t       dst1_r, dst2_r, dst3_r;
  logic [AAW-1:0] daddr1_r, daddr2_r, daddr3_r;

  logic [OUT_W-1:0] res0_r, res1_r;
  logic [OUT_W-1:0] out_zero_r, out_one_r;
  logic             out_dec_r;
  logic [OUT_W-1:0] node_val;

  assign node_val = relu_sat(acc_r);

  // weight memory: write from requests, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wt_we && (32'(in_weight_index) < WCOUNT)) begin
      wmem[WAW'(in_weight_index)] <= in_weight_value;
    end
    if (cmd.rd_en) begin
      w_rd_r <= wmem[w_raddr];
    end
  end

  // activation memory: inputs then two ping-pong hidden banks
  always_ff @(posedge clk) begin
    if (cmd.feat_we) begin
      amem[feat_addr] <= in_feature_value;
    end else if (done_r && (dst3_r == DST_MEM)) begin
      amem[daddr3_r] <= ACT_W'(node_val);
    end
    if (cmd.rd_en) begin
      a_rd_r <= amem[act_raddr];
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      v1_r   <= cmd.rd_en;
      v2_r   <= v1_r;
      done_r <= v2_r && last2_r;
      if (v2_r) begin
        acc_r <= (first2_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);
      end
    end
  end

  // tags and products
  always_ff @(posedge clk) begin
    first1_r <= cmd.first;
    last1_r  <= cmd.last;
    dst1_r   <= cmd.dst;
    daddr1_r <= dst_addr;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    dst2_r   <= dst1_r;
    daddr2_r <= daddr1_r;
    dst3_r   <= dst2_r;
    daddr3_r <= daddr2_r;
    prod_r   <= w_rd_r * a_rd_r;
  end

  // output node capture and result register
  always_ff @(posedge clk) begin
    if (done_r) begin
      case (dst3_r)
        DST_OUT0: res0_r <= node_val;
        DST_OUT1: res1_r <= node_val;
        default:  ;
      endcase
    end
    if (cmd.load_out) begin
      out_zero_r <= res0_r;
      out_one_r  <= res1_r;
      out_dec_r  <= res0_r > res1_r;
    end
  end

  assign pipe_busy    = v1_r | v2_r | done_r;
  assign out_decision = out_dec_r;
  assign out_zero     = out_zero_r;
  assign out_one      = out_one_r;

endmodule

// ===== src/mri_ctrl.sv =====
// ----------------------------------------------------------------------------
// mri_ctrl: sequencer for request handling and the layer-by-layer sweep
// Walks layers, nodes and terms; drains the MAC pipe between layers.
// ----------------------------------------------------------------------------
module mri_ctrl #(
  parameter int IN  = 4,
  parameter int H   = 8,
  parameter int L   = 2,
  parameter int WAW = 7,
  parameter int AAW = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              pipe_busy,
  output mri_pkg::mri_cmd_t cmd,
  output logic [WAW-1:0]    w_raddr,
  output logic [AAW-1:0]    act_raddr,
  output logic [AAW-1:0]    dst_addr,
  output logic [AAW-1:0]    feat_addr
);
  import mri_pkg::*;

  localparam int MAXN = (IN > H) ? IN : H;
  localparam int NMAX = (H > 2) ? H : 2;
  localparam int CW   = $clog2(IN + 1);
  localparam int JW   = $clog2(MAXN + 1);
  localparam int NW   = $clog2(NMAX + 1);
  localparam int LW   = $clog2(L + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [LW-1:0]  layer_r, layer_nxt;
  logic [NW-1:0]  node_r, node_nxt;
  logic [JW-1:0]  j_r, j_nxt;
  logic [WAW-1:0] w_r, w_nxt;
  logic [AAW-1:0] src_r, src_nxt, dst_r, dst_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [JW-1:0]  j_last;
  logic [NW-1:0]  node_last;
  logic           out_layer;

  assign out_layer = (layer_r == LW'(L));
  assign j_last    = (layer_r == '0) ? JW'(IN - 1) : JW'(H - 1);
  assign node_last = out_layer ? NW'(1) : NW'(H - 1);

  assign w_raddr   = w_r;
  assign act_raddr = src_r + AAW'(j_r);
  assign dst_addr  = dst_r + AAW'(node_r);
  assign feat_addr = AAW'(cnt_r);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    layer_nxt     = layer_r;
    node_nxt      = node_r;
    j_nxt         = j_r;
    w_nxt         = w_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.dst       = DST_MEM;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_FEATURE) begin
            cmd.feat_we = 1'b1;
            if (cnt_r == CW'(IN - 1)) begin
              cnt_nxt   = '0;
              layer_nxt = '0;
              node_nxt  = '0;
              j_nxt     = '0;
              w_nxt     = '0;
              src_nxt   = '0;
              dst_nxt   = AAW'(IN);
              state_nxt = S_RUN;
            end else begin
              cnt_nxt = cnt_r + CW'(1);
            end
          end else begin
            cmd.wt_we = 1'b1;
          end
        end
      end

      S_RUN: begin
        cmd.rd_en = 1'b1;
        cmd.first = (j_r == '0);
        cmd.last  = (j_r == j_last);
        if (out_layer) begin
          cmd.dst = (node_r == '0) ? DST_OUT0 : DST_OUT1;
        end
        w_nxt = w_r + WAW'(1);
        if (j_r == j_last) begin
          j_nxt = '0;
          if (node_r == node_last) begin
            node_nxt  = '0;
            state_nxt = S_DRAIN;
          end else begin
            node_nxt = node_r + NW'(1);
          end
        end else begin
          j_nxt = j_r + JW'(1);
        end
      end

      S_DRAIN: begin
        if (!pipe_busy) begin
          if (out_layer) begin
            state_nxt = S_DONE;
          end else begin
            layer_nxt = layer_r + LW'(1);
            src_nxt   = dst_r;
            dst_nxt   = (layer_r == '0) ? AAW'(IN + H) : src_r;
            state_nxt = S_RUN;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      layer_r     <= '0;
      node_r      <= '0;
      j_r         <= '0;
      w_r         <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      layer_r     <= layer_nxt;
      node_r      <= node_nxt;
      j_r         <= j_nxt;
      w_r         <= w_nxt;
      src_r       <= src_nxt;
      dst_r       <= dst_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/mlp_relu_inference_core.sv =====
// Timing: a weight request or a non-final feature only updates memory or the
//   feature count. The final feature of a vector starts a sweep of all layers
//   before the result request is offered; requests wait during the sweep.
// Throughput: one vector per sweep plus its IN feature requests; the single
//   MAC and the one-read-per-cycle weight memory set it.
// Reset: synchronous, active low; clears control, the feature count and the accumulator only.
// ----------------------------------------------------------------------------
// mlp_relu_inference_core: fixed-point MLP forward pass with ReLU
// Weight requests fill the weight memory; feature requests build the input
// vector; a full vector runs all layers on one shared MAC and yields a result.
// ----------------------------------------------------------------------------
module mlp_relu_inference_core #(
  parameter int INPUT_NODES   = 4,
  parameter int HIDDEN_NODES  = 8,
  parameter int HIDDEN_LAYERS = 2,
  parameter int OUTPUT_NODES  = 2
) (
  input logic       clk,
  input logic       rst_n,
  mri_in_if.sink    in_req,
  mri_out_if.source out_res
);
  import mri_pkg::*;

  // weight memory layout: input-to-hidden, hidden layers, hidden-to-output
  localparam int IH_SIZE      = INPUT_NODES * HIDDEN_NODES;
  localparam int HH_SIZE      = HIDDEN_NODES * HIDDEN_NODES;
  localparam int HO_BASE      = IH_SIZE + (HIDDEN_LAYERS - 1) * HH_SIZE;
  localparam int WEIGHT_COUNT = HO_BASE + OUTPUT_NODES * HIDDEN_NODES;
  // activation memory: input vector, then two ping-pong hidden banks
  localparam int ACT_DEPTH    = INPUT_NODES + 2 * HIDDEN_NODES;
  localparam int WAW          = $clog2(WEIGHT_COUNT);
  localparam int AAW          = $clog2(ACT_DEPTH);

  mri_cmd_t       cmd;
  logic           pipe_busy;
  logic [WAW-1:0] w_raddr;
  logic [AAW-1:0] act_raddr;
  logic [AAW-1:0] dst_addr;
  logic [AAW-1:0] feat_addr;

  // sequencer: request acceptance, layer/node/term sweep, result handshake
  mri_ctrl #(
    .IN  (INPUT_NODES),
    .H   (HIDDEN_NODES),
    .L   (HIDDEN_LAYERS),
    .WAW (WAW),
    .AAW (AAW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_command (in_req.command),
    .in_ready   (in_req.ready),
    .out_valid  (out_res.valid),
    .out_ready  (out_res.ready),
    .pipe_busy  (pipe_busy),
    .cmd        (cmd),
    .w_raddr    (w_raddr),
    .act_raddr  (act_raddr),
    .dst_addr   (dst_addr),
    .feat_addr  (feat_addr)
  );

  // memories, MAC pipeline, ReLU write-back and the result register
  mri_datapath #(
    .WCOUNT (WEIGHT_COUNT),
    .ADEPTH (ACT_DEPTH),
    .WAW    (WAW),
    .AAW    (AAW)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .w_raddr          (w_raddr),
    .act_raddr        (act_raddr),
    .dst_addr         (dst_addr),
    .feat_addr        (feat_addr),
    .in_weight_index  (in_req.weight_index),
    .in_weight_value  (in_req.weight_value),
    .in_feature_value (in_req.feature_value),
    .pipe_busy        (pipe_busy),
    .out_decision     (out_res.decision),
    .out_zero         (out_res.output_zero),
    .out_one          (out_res.output_one)
  );

endmodule

// ===== src/mri_checker.sv =====
// ----------------------------------------------------------------------------
// mri_checker: port-level checks on the result channel of the core
// Bound to the top level; watches the result handshake and payload only.
// ----------------------------------------------------------------------------
module mri_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      decision,
  input logic [mri_pkg::OUT_W-1:0] output_zero,
  input logic [mri_pkg::OUT_W-1:0] output_one
);
  import mri_pkg::*;

  // a stalled result request stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request withdrawn while stalled");

  // a stalled result request keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(decision) && $stable(output_zero) && $stable(output_one))
    else $error("result payload changed while stalled");

  // decision agrees with the two saturated outputs
  a_decision: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> decision == (output_zero > output_one))
    else $error("decision does not match output values");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind mlp_relu_inference_core mri_checker u_mri_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .decision    (out_res.decision),
  .output_zero (out_res.output_zero),
  .output_one  (out_res.output_one)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the MLP ReLU inference core
// Drives weight and feature requests through the valid/ready request channel,
// predicts every forward pass in fixed point and compares each result field.
// ----------------------------------------------------------------------------
module tb;
  import mri_pkg::*;

  // network shape, kept in step with the instance below
  localparam int IN_N    = 4;
  localparam int HID_N   = 8;
  localparam int HID_L   = 2;
  localparam int OUT_N   = 2;
  localparam int LAYER_W = (IN_N > HID_N) ? IN_N : HID_N;

  // weight memory layout: input-to-hidden, hidden-to-hidden, hidden-to-output
  localparam int IH_SIZE      = IN_N * HID_N;
  localparam int HH_SIZE      = HID_N * HID_N;
  localparam int HO_BASE      = IH_SIZE + (HID_L - 1) * HH_SIZE;
  localparam int WEIGHT_TOTAL = HO_BASE + OUT_N * HID_N;

  localparam logic [WT_W-1:0]  WT_TOP     = 16'h7FFF;
  localparam logic [WT_W-1:0]  WT_BOTTOM  = 16'h8000;
  localparam logic [ACT_W-1:0] ACT_TOP    = 16'h7FFF;
  localparam logic [ACT_W-1:0] ACT_BOTTOM = 16'h8000;

  localparam int WT_SPREAD    = 2500;  // about +/-0.6 in Q4.12
  localparam int ACT_SPREAD   = 2000;  // about +/-8 in Q8.8
  localparam int RANDOM_ITEMS = 700;
  localparam int SWEEP_CYCLES = 160;   // margin for the last sweep to finish
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic             decision;
    logic [OUT_W-1:0] node0;
    logic [OUT_W-1:0] node1;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  mri_in_if  in_req();
  mri_out_if out_res();

  mlp_relu_inference_core #(
    .INPUT_NODES   (IN_N),
    .HIDDEN_NODES  (HID_N),
    .HIDDEN_LAYERS (HID_L),
    .OUTPUT_NODES  (OUT_N)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow of the network state, updated as each request is accepted
  // --------------------------------------------------------------------------
  logic signed [WT_W-1:0]  weight_mem  [WEIGHT_TOTAL];
  logic signed [ACT_W-1:0] feature_vec [IN_N];
  logic signed [ACT_W-1:0] layer_src   [LAYER_W];   // activations feeding a layer
  int unsigned             features_held;

  verdict_t pending_verdicts[$];   // forward passes still to come out
  verdict_t want;

  // run statistics
  int unsigned items_sent;
  int unsigned weight_writes;
  int unsigned ignored_writes;
  int unsigned features_taken;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          steady;             // set: neither side idles

  // One node: exact dot product, then ReLU with truncation and saturation.
  function automatic logic [OUT_W-1:0] neuron(input int n, input int base);
    longint acc;
    longint scaled;
    int     j;
    acc = 0;
    for (j = 0; j < n; j++) begin
      acc += longint'(layer_src[j]) * longint'(weight_mem[base + j]);
    end
    if (acc <= 0) begin
      return '0;
    end
    scaled = acc >>> FRAC_SHIFT;
    if (scaled > longint'(ACT_MAX)) begin
      return ACT_MAX;
    end
    return scaled[OUT_W-1:0];
  endfunction

  // Whole network on the buffered feature vector.
  function automatic verdict_t forward_pass();
    verdict_t         v;
    logic [OUT_W-1:0] node_out [LAYER_W];
    logic [OUT_W-1:0] o0;
    logic [OUT_W-1:0] o1;
    int               i;
    int               k;
    for (i = 0; i < IN_N; i++) begin
      layer_src[i] = feature_vec[i];
    end
    for (i = 0; i < HID_N; i++) begin
      node_out[i] = neuron(IN_N, i * IN_N);
    end
    for (k = 0; k < HID_L - 1; k++) begin
      for (i = 0; i < HID_N; i++) begin
        layer_src[i] = {1'b0, node_out[i]};
      end
      for (i = 0; i < HID_N; i++) begin
        node_out[i] = neuron(HID_N, IH_SIZE + k * HH_SIZE + i * HID_N);
      end
    end
    for (i = 0; i < HID_N; i++) begin
      layer_src[i] = {1'b0, node_out[i]};
    end
    o0 = neuron(HID_N, HO_BASE);
    o1 = neuron(HID_N, HO_BASE + HID_N);
    // saturated values compared, so two saturated outputs give 0
    v.decision = (o0 > o1);
    v.node0    = o0;
    v.node1    = o1;
    return v;
  endfunction

  // Apply one accepted request to the shadow state.
  task automatic take_request(input logic cmd, input logic [IDX_W-1:0] idx,
                              input logic [WT_W-1:0] wv, input logic [ACT_W-1:0] fv);
    if (cmd == CMD_WEIGHT) begin
      if (int'(idx) < WEIGHT_TOTAL) begin
        weight_mem[idx] = wv;
        weight_writes++;
        items_sent++;
      end else begin
        ignored_writes++;   // beyond the weight memory: no effect
      end
    end else begin
      items_sent++;
      features_taken++;
      feature_vec[features_held] = fv;
      features_held++;
      if (features_held == IN_N) begin
        features_held = 0;
        pending_verdicts.push_back(forward_pass());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Request side. valid is left high after an acceptance; the next call either
  // keeps it high or drops it for a gap, so it never sees two updates in a step.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic cmd, input logic [IDX_W-1:0] idx,
                              input logic [WT_W-1:0] wv, input logic [ACT_W-1:0] fv);
    if (!steady && $urandom_range(99) < 12) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_req.valid         <= 1'b1;
    in_req.command       <= cmd;
    in_req.weight_index  <= idx;
    in_req.weight_value  <= wv;
    in_req.feature_value <= fv;
    @(posedge clk);
    while (!in_req.ready) begin
      @(posedge clk);
    end
    take_request(cmd, idx, wv, fv);
  endtask

  // unused fields carry noise so the block cannot lean on them
  task automatic write_weight(input int idx, input logic [WT_W-1:0] val);
    send_request(CMD_WEIGHT, IDX_W'(idx), val, ACT_W'($urandom));
  endtask

  task automatic send_feature(input logic [ACT_W-1:0] val);
    send_request(CMD_FEATURE, IDX_W'($urandom), WT_W'($urandom), val);
  endtask

  // Mostly moderate values so that ReLU outputs vary, with extremes mixed in.
  function automatic logic [WT_W-1:0] pick_word(input int spread);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 6) begin
      return 16'h7FFF;
    end
    if (roll < 12) begin
      return 16'h8000;
    end
    if (roll < 16) begin
      return '0;
    end
    if (roll < 30) begin
      return WT_W'($urandom);
    end
    return WT_W'(int'($urandom_range(2 * spread)) - spread);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the field-by-field check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_res.ready <= steady || ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, actual decision %0d zero %0d one %0d",
                 $time, out_res.decision, out_res.output_zero, out_res.output_one);
      end else begin
        want = pending_verdicts.pop_front();
        results_checked++;
        if (out_res.decision !== want.decision) begin
          mismatches++;
          $display("%0t: decision mismatch, expected %0d actual %0d",
                   $time, want.decision, out_res.decision);
        end
        if (out_res.output_zero !== want.node0) begin
          mismatches++;
          $display("%0t: output_zero mismatch, expected %0d actual %0d",
                   $time, want.node0, out_res.output_zero);
        end
        if (out_res.output_one !== want.node1) begin
          mismatches++;
          $display("%0t: output_one mismatch, expected %0d actual %0d",
                   $time, want.node1, out_res.output_one);
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no request or result moved for %0d cycles",
               $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every weight written before any vector completes; all at the positive limit.
  task automatic test_weight_fill();
    int i;
    for (i = 0; i < WEIGHT_TOTAL; i++) begin
      write_weight(i, WT_TOP);
    end
  endtask

  // Largest features: both outputs saturate and tie, so decision is 0.
  // A weight write in mid-vector must not move the feature count.
  task automatic test_saturation_tie();
    send_feature(ACT_TOP);
    send_feature(ACT_TOP);
    write_weight(0, WT_TOP);
    send_feature(ACT_TOP);
    send_feature(ACT_TOP);
  endtask

  // Most negative features: every first-layer sum is negative, all nodes clamp to zero.
  task automatic test_zero_vector();
    repeat (IN_N) send_feature(ACT_BOTTOM);
  endtask

  // Writes beyond the weight memory are dropped; the saturated tie must repeat.
  task automatic test_ignored_index();
    write_weight(WEIGHT_TOTAL, WT_BOTTOM);
    write_weight((1 << IDX_W) - 1, WT_BOTTOM);
    repeat (IN_N) send_feature(ACT_TOP);
  endtask

  // Output node 1 weights at the negative limit: node 0 saturates, node 1 is 0.
  task automatic test_split_decision();
    int i;
    for (i = 0; i < HID_N; i++) begin
      write_weight(HO_BASE + HID_N + i, WT_BOTTOM);
    end
    send_feature(ACT_TOP);
    send_feature('0);
    send_feature(16'h0001);
    send_feature(16'hFFFF);
  endtask

  // Mostly weight updates followed by a whole vector, some noise and some
  // stray features that leave a vector part-filled.
  task automatic test_random_traffic();
    int          i;
    int unsigned roll;
    int unsigned first_item;
    first_item = items_sent;
    for (i = 0; i < WEIGHT_TOTAL; i++) begin
      write_weight(i, pick_word(WT_SPREAD));
    end
    while (items_sent - first_item < RANDOM_ITEMS) begin
      // a long run with both sides flat out in the middle
      steady = (items_sent - first_item >= 350) && (items_sent - first_item < 500);
      roll = $urandom_range(99);
      if (roll < 80) begin
        repeat ($urandom_range(0, 6)) begin
          write_weight($urandom_range(WEIGHT_TOTAL - 1), pick_word(WT_SPREAD));
        end
        for (i = 0; i < IN_N; i++) begin
          if ($urandom_range(99) < 15) begin
            write_weight($urandom_range(WEIGHT_TOTAL - 1), pick_word(WT_SPREAD));
          end
          send_feature(pick_word(ACT_SPREAD));
        end
      end else if (roll < 90) begin
        if ($urandom_range(1)) begin
          write_weight($urandom_range(WEIGHT_TOTAL, (1 << IDX_W) - 1), WT_W'($urandom));
        end else begin
          write_weight($urandom_range(WEIGHT_TOTAL - 1), WT_W'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, IN_N - 1)) send_feature(ACT_W'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    steady               = 1'b0;
    in_req.valid         = 1'b0;
    in_req.command       = CMD_WEIGHT;
    in_req.weight_index  = '0;
    in_req.weight_value  = '0;
    in_req.feature_value = '0;
    out_res.ready        = 1'b0;
    features_held        = 0;
    items_sent           = 0;
    weight_writes        = 0;
    ignored_writes       = 0;
    features_taken       = 0;
    results_checked      = 0;
    mismatches           = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_weight_fill();
    test_saturation_tie();
    test_zero_vector();
    test_ignored_index();
    test_split_decision();
    test_random_traffic();

    // last request accepted at this edge; valid has had no update here yet
    in_req.valid <= 1'b0;
    while (pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (SWEEP_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d weight writes, %0d dropped writes, %0d features",
             items_sent + ignored_writes, weight_writes, ignored_writes, features_taken);
    $display("Checked %0d forward passes (saturated tie, zero vector, split decision, random)",
             results_checked);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
